/* hdl/kdq_pkg.sv */
// Package for the keyed deque with key search.
// Holds command and status codes, controller states and default sizes.
// Depends on nothing; used by keyed_deque_with_search_top.
package kdq_pkg;

  localparam int DEPTH_DEFAULT        = 16;
  localparam int PAYLOAD_BITS_DEFAULT = 32;
  localparam int KEY_BITS             = 32;
  localparam int PAYLOAD_PORT_BITS    = 32;
  localparam int PAYLOAD_WIDE_BITS    = 64;
  localparam int CMD_BITS             = 3;
  localparam int STATUS_BITS          = 2;

  localparam logic [CMD_BITS-1:0] CMD_PUSH_FRONT = 3'd0;
  localparam logic [CMD_BITS-1:0] CMD_PUSH_REAR  = 3'd1;
  localparam logic [CMD_BITS-1:0] CMD_POP_FRONT  = 3'd2;
  localparam logic [CMD_BITS-1:0] CMD_POP_REAR   = 3'd3;
  localparam logic [CMD_BITS-1:0] CMD_FIND       = 3'd4;

  localparam logic [STATUS_BITS-1:0] STATUS_OK    = 2'd0;
  localparam logic [STATUS_BITS-1:0] STATUS_EMPTY = 2'd1;
  localparam logic [STATUS_BITS-1:0] STATUS_FULL  = 2'd2;
  localparam logic [STATUS_BITS-1:0] STATUS_MISS  = 2'd3;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_POP,
    ST_SCAN
  } kdq_state_t;

endpackage

/* hdl/keyed_deque_with_search_top.sv */
// Keyed deque with key search: controller, ring pointers and record memory.
// Depends on kdq_pkg for codes, states and default sizes.
// Records live in one synchronous memory with a registered read.

// A request is taken when start is high and busy is low; its one result
// appears one or more cycles later for a single cycle with done high, and
// the receiver must take it then. A push takes one cycle, a pop two, and a
// find one cycle per record compared plus one, so at most DEPTH + 1 cycles:
// the records sit in a single-port memory that the search reads one entry
// per cycle from the front. The count port gives the number of records held
// and is valid in the done cycle. No clearing is needed after reset.
module keyed_deque_with_search_top #(
  parameter int DEPTH        = kdq_pkg::DEPTH_DEFAULT,
  parameter int PAYLOAD_BITS = kdq_pkg::PAYLOAD_BITS_DEFAULT
) (
  input  logic                                      clk,
  input  logic                                      rst,
  input  logic                                      start,
  output logic                                      busy,
  input  logic [kdq_pkg::CMD_BITS-1:0]              command,
  input  logic signed [kdq_pkg::KEY_BITS-1:0]       key,
  input  logic [kdq_pkg::PAYLOAD_PORT_BITS-1:0]     payload,
  output logic                                      done,
  output logic [kdq_pkg::STATUS_BITS-1:0]           status,
  output logic signed [kdq_pkg::KEY_BITS-1:0]       out_key,
  output logic [kdq_pkg::PAYLOAD_PORT_BITS-1:0]     out_payload,
  output logic [$clog2(DEPTH+1)-1:0]                count
);

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);
  localparam int SW = CW + 1;
  localparam int KB = kdq_pkg::KEY_BITS;
  localparam int EW = KB + PAYLOAD_BITS;

  function automatic logic [IW-1:0] ring_add(input logic [IW-1:0] base,
                                             input logic [CW-1:0] off);
    logic [SW-1:0] sum;
    sum = SW'(base) + SW'(off);
    if (sum >= SW'(DEPTH)) begin
      sum = sum - SW'(DEPTH);
    end
    return sum[IW-1:0];
  endfunction

  logic [EW-1:0] mem [DEPTH];
  logic [EW-1:0] rdata;
  logic          wr_en;
  logic [IW-1:0] wr_addr;
  logic [EW-1:0] wr_data;
  logic          rd_en;
  logic [IW-1:0] rd_addr;

  kdq_pkg::kdq_state_t state, state_next;
  logic [IW-1:0] first_slot, first_slot_next;
  logic [CW-1:0] entry_count, entry_count_next;
  logic [IW-1:0] scan_addr, scan_addr_next;
  logic [CW-1:0] scan_idx, scan_idx_next;
  logic [KB-1:0] key_q, key_q_next;
  logic          done_next;
  logic [kdq_pkg::STATUS_BITS-1:0]       status_next;
  logic [KB-1:0]                         out_key_next;
  logic [kdq_pkg::PAYLOAD_PORT_BITS-1:0] out_payload_next;

  logic [kdq_pkg::PAYLOAD_WIDE_BITS-1:0] pay_in_wide;
  logic [kdq_pkg::PAYLOAD_WIDE_BITS-1:0] pay_rd_wide;
  logic [KB-1:0]                         rd_key;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_comb begin
    pay_in_wide = kdq_pkg::PAYLOAD_WIDE_BITS'(payload);
    pay_rd_wide = '0;
    pay_rd_wide[PAYLOAD_BITS-1:0] = rdata[PAYLOAD_BITS-1:0];
    rd_key = rdata[EW-1:PAYLOAD_BITS];
  end

  always_comb begin
    state_next       = state;
    first_slot_next  = first_slot;
    entry_count_next = entry_count;
    scan_addr_next   = scan_addr;
    scan_idx_next    = scan_idx;
    key_q_next       = key_q;
    done_next        = 1'b0;
    status_next      = status;
    out_key_next     = out_key;
    out_payload_next = out_payload;
    wr_en            = 1'b0;
    wr_addr          = first_slot;
    wr_data          = {key, pay_in_wide[PAYLOAD_BITS-1:0]};
    rd_en            = 1'b0;
    rd_addr          = first_slot;

    unique case (state)
      kdq_pkg::ST_IDLE: begin
        if (start) begin
          done_next        = 1'b1;
          status_next      = kdq_pkg::STATUS_OK;
          out_key_next     = '0;
          out_payload_next = '0;
          key_q_next       = key;
          unique case (command) inside
            kdq_pkg::CMD_PUSH_FRONT, kdq_pkg::CMD_PUSH_REAR: begin
              if (entry_count == CW'(DEPTH)) begin
                status_next = kdq_pkg::STATUS_FULL;
              end else begin
                wr_en            = 1'b1;
                entry_count_next = entry_count + 1'b1;
                if (command == kdq_pkg::CMD_PUSH_FRONT) begin
                  wr_addr         = ring_add(first_slot, CW'(DEPTH - 1));
                  first_slot_next = wr_addr;
                end else begin
                  wr_addr = ring_add(first_slot, entry_count);
                end
              end
            end
            kdq_pkg::CMD_POP_FRONT, kdq_pkg::CMD_POP_REAR: begin
              if (entry_count == '0) begin
                status_next = kdq_pkg::STATUS_EMPTY;
              end else begin
                done_next        = 1'b0;
                rd_en            = 1'b1;
                entry_count_next = entry_count - 1'b1;
                state_next       = kdq_pkg::ST_POP;
                if (command == kdq_pkg::CMD_POP_FRONT) begin
                  rd_addr         = first_slot;
                  first_slot_next = ring_add(first_slot, CW'(1));
                end else begin
                  rd_addr = ring_add(first_slot, entry_count - 1'b1);
                end
              end
            end
            kdq_pkg::CMD_FIND: begin
              if (entry_count == '0) begin
                status_next = kdq_pkg::STATUS_EMPTY;
              end else begin
                done_next      = 1'b0;
                rd_en          = 1'b1;
                rd_addr        = first_slot;
                scan_addr_next = ring_add(first_slot, CW'(1));
                scan_idx_next  = '0;
                state_next     = kdq_pkg::ST_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      kdq_pkg::ST_POP: begin
        done_next        = 1'b1;
        status_next      = kdq_pkg::STATUS_OK;
        out_key_next     = rd_key;
        out_payload_next = pay_rd_wide[kdq_pkg::PAYLOAD_PORT_BITS-1:0];
        state_next       = kdq_pkg::ST_IDLE;
      end
      kdq_pkg::ST_SCAN: begin
        if (rd_key == key_q) begin
          done_next        = 1'b1;
          status_next      = kdq_pkg::STATUS_OK;
          out_key_next     = rd_key;
          out_payload_next = pay_rd_wide[kdq_pkg::PAYLOAD_PORT_BITS-1:0];
          state_next       = kdq_pkg::ST_IDLE;
        end else if (CW'(scan_idx + 1'b1) == entry_count) begin
          done_next   = 1'b1;
          status_next = kdq_pkg::STATUS_MISS;
          state_next  = kdq_pkg::ST_IDLE;
        end else begin
          rd_en          = 1'b1;
          rd_addr        = scan_addr;
          scan_addr_next = ring_add(scan_addr, CW'(1));
          scan_idx_next  = scan_idx + 1'b1;
        end
      end
      default: begin
        state_next = kdq_pkg::ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= kdq_pkg::ST_IDLE;
      first_slot  <= '0;
      entry_count <= '0;
      done        <= 1'b0;
    end else begin
      state       <= state_next;
      first_slot  <= first_slot_next;
      entry_count <= entry_count_next;
      done        <= done_next;
    end
    scan_addr   <= scan_addr_next;
    scan_idx    <= scan_idx_next;
    key_q       <= key_q_next;
    status      <= status_next;
    out_key     <= out_key_next;
    out_payload <= out_payload_next;
  end

  assign busy  = (state != kdq_pkg::ST_IDLE);
  assign count = entry_count;

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    entry_count <= CW'(DEPTH))
    else $error("record count exceeds the depth");

  a_full_status: assert property (@(posedge clk) disable iff (rst)
    done && status == kdq_pkg::STATUS_FULL |-> count == CW'(DEPTH))
    else $error("full status reported while the store has room");

  a_empty_status: assert property (@(posedge clk) disable iff (rst)
    done && status == kdq_pkg::STATUS_EMPTY |-> count == '0)
    else $error("empty status reported while records are held");

  a_pop_count: assert property (@(posedge clk) disable iff (rst)
    start && !busy && entry_count != '0 &&
    (command == kdq_pkg::CMD_POP_FRONT || command == kdq_pkg::CMD_POP_REAR)
    |=> entry_count == CW'($past(entry_count) - 1'b1))
    else $error("pop did not lower the record count by one");

endmodule
